// ----- hdl/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared constants, operation codes and lane stage enables for the spline
// evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crs_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    // Headroom above the coordinate width for the lane intermediates
    localparam int GUARD_BITS = 7;

    // Smallest usable point count, also the reset value of the register
    localparam int NUM_POINTS_MIN = 2;

    // Operation codes of an input transaction
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Load enables for the lane pipeline stages
    typedef struct packed {
        logic rd;    // table read
        logic coef;  // basis coefficients
        logic mul1;  // first Horner step
        logic mul2;  // second Horner step
        logic mul3;  // final Horner step
    } t_lane_en;

endpackage

// ----- hdl/crs_index.sv -----
// ----------------------------------------------------------------------------
// crs_index
// Section search: scales t by the section count, then derives the section,
// the four neighbour indices (clamped into the table) and the local u.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_index import crs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int NW = $clog2(MAX_POINTS + 1),
    localparam int TW = T_FRAC_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [TW-1:0] i_t,
    input  logic [NW-1:0] i_num,
    output logic [AW-1:0] o_ia,
    output logic [AW-1:0] o_ib,
    output logic [AW-1:0] o_ic,
    output logic [AW-1:0] o_id,
    output logic [TW-1:0] o_u
);

    localparam logic [TW-1:0] T_ONE   = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [NW-1:0] N_MIN   = NW'(NUM_POINTS_MIN);
    localparam logic [NW-1:0] N_MAX   = NW'(MAX_POINTS);
    localparam int            PW      = TW + AW;

    logic [NW-1:0] w_num;
    logic [AW-1:0] w_secs;
    logic [TW-1:0] w_t;
    logic [PW-1:0] n_tns;
    logic [PW-1:0] r_tns;
    logic [AW-1:0] r_secs;
    logic [AW:0]   w_sec_raw;
    logic [AW-1:0] w_sec;
    logic [AW:0]   w_sec2;

    // Clamp the point count and t, then scale
    always_comb begin
        if (i_num < N_MIN) begin
            w_num = N_MIN;
        end else if (i_num > N_MAX) begin
            w_num = N_MAX;
        end else begin
            w_num = i_num;
        end
        w_secs = AW'(w_num - NW'(1));
        w_t    = (i_t > T_ONE) ? T_ONE : i_t;
        n_tns  = PW'(w_t) * PW'(w_secs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tns  <= n_tns;
            r_secs <= w_secs;
        end
    end

    // t equal to one lands in the last section with u at one
    always_comb begin
        w_sec_raw = r_tns[PW-1:T_FRAC_BITS];
        if (w_sec_raw >= {1'b0, r_secs}) begin
            w_sec = r_secs - AW'(1);
        end else begin
            w_sec = w_sec_raw[AW-1:0];
        end
        w_sec2 = {1'b0, w_sec} + (AW+1)'(2);
        o_ia   = (w_sec == '0) ? '0 : w_sec - AW'(1);
        o_ib   = w_sec;
        o_ic   = w_sec + AW'(1);
        o_id   = (w_sec2 > {1'b0, r_secs}) ? r_secs : w_sec2[AW-1:0];
        o_u    = TW'(r_tns - (PW'(w_sec) << T_FRAC_BITS));
    end

endmodule

// ----- hdl/crs_lane.sv -----
// ----------------------------------------------------------------------------
// crs_lane
// One coordinate axis: its slice of the point table and a five-stage
// Horner pipeline for position and slope, before saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_lane import crs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int UW = T_FRAC_BITS + 1,
    localparam int RW = COORD_WIDTH + GUARD_BITS
) (
    input  logic                          i_clk,
    input  t_lane_en                      i_en,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic signed [COORD_WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]                 i_ia,
    input  logic [AW-1:0]                 i_ib,
    input  logic [AW-1:0]                 i_ic,
    input  logic [AW-1:0]                 i_id,
    input  logic [UW-1:0]                 i_u,
    output logic signed [RW-1:0]          o_value,
    output logic signed [RW-1:0]          o_slope
);

    localparam int F  = T_FRAC_BITS;
    localparam int PW = RW + F;
    localparam int MW = RW + UW + 1;

    localparam logic signed [RW-1:0] K2 = RW'(2);
    localparam logic signed [RW-1:0] K3 = RW'(3);
    localparam logic signed [RW-1:0] K4 = RW'(4);
    localparam logic signed [RW-1:0] K5 = RW'(5);
    localparam logic signed [PW-1:0] HALF_F  = PW'(1) <<< (F - 1);
    localparam logic signed [PW-1:0] HALF_F1 = PW'(1) <<< F;

    // Two copies of the table, each serving two reads
    logic signed [COORD_WIDTH-1:0] r_tab_ab [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] r_tab_cd [MAX_POINTS];

    logic signed [COORD_WIDTH-1:0] r_a, r_b, r_c, r_d;
    logic [UW-1:0]                 r_u0, r_u1, r_u2, r_u3;
    logic signed [RW-1:0]          r_ca, r_cb, r_cc1, r_cd1;
    logic signed [RW-1:0]          r_h1, r_g1, r_cc2, r_cd2;
    logic signed [RW-1:0]          r_h2, r_gs, r_cd3;
    logic signed [RW-1:0]          r_val, r_slp;

    logic signed [RW-1:0] w_a, w_b, w_c, w_d;
    logic signed [RW-1:0] n_ca, n_cb, n_cc, n_cd;
    logic signed [UW:0]   w_us1, w_us2, w_us3;
    logic signed [MW-1:0] w_p1, w_p2h, w_p2g, w_p3;
    logic signed [PW-1:0] w_q1, w_s1h, w_s1g, w_s2h, w_s2g, w_s3;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tab_ab[i_wr_addr] <= i_wr_data;
            r_tab_cd[i_wr_addr] <= i_wr_data;
        end
        if (i_en.rd) begin
            r_a  <= r_tab_ab[i_ia];
            r_b  <= r_tab_ab[i_ib];
            r_c  <= r_tab_cd[i_ic];
            r_d  <= r_tab_cd[i_id];
            r_u0 <= i_u;
        end
    end

    // Basis coefficients of the uniform segment
    always_comb begin
        w_a  = RW'(r_a);
        w_b  = RW'(r_b);
        w_c  = RW'(r_c);
        w_d  = RW'(r_d);
        n_ca = K3 * (w_b - w_c) + w_d - w_a;
        n_cb = K2 * w_a - K5 * w_b + K4 * w_c - w_d;
        n_cc = w_c - w_a;
        n_cd = K2 * w_b;
    end

    // Horner steps; position and slope share the first product
    always_comb begin
        w_us1 = $signed({1'b0, r_u1});
        w_us2 = $signed({1'b0, r_u2});
        w_us3 = $signed({1'b0, r_u3});

        w_p1  = r_ca * w_us1;
        w_q1  = $signed(w_p1[PW-1:0]);
        w_s1h = w_q1 + (PW'(r_cb) <<< F) + HALF_F;
        w_s1g = (w_q1 <<< 1) + w_q1 + (PW'(r_cb) <<< (F + 1)) + HALF_F;

        w_p2h = r_h1 * w_us2;
        w_p2g = r_g1 * w_us2;
        w_s2h = $signed(w_p2h[PW-1:0]) + (PW'(r_cc2) <<< F) + HALF_F;
        w_s2g = $signed(w_p2g[PW-1:0]) + (PW'(r_cc2) <<< F) + HALF_F1;

        w_p3  = r_h2 * w_us3;
        w_s3  = $signed(w_p3[PW-1:0]) + (PW'(r_cd3) <<< F) + HALF_F1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.coef) begin
            r_ca  <= n_ca;
            r_cb  <= n_cb;
            r_cc1 <= n_cc;
            r_cd1 <= n_cd;
            r_u1  <= r_u0;
        end
        if (i_en.mul1) begin
            r_h1  <= $signed(w_s1h[PW-1:F]);
            r_g1  <= $signed(w_s1g[PW-1:F]);
            r_cc2 <= r_cc1;
            r_cd2 <= r_cd1;
            r_u2  <= r_u1;
        end
        if (i_en.mul2) begin
            r_h2  <= $signed(w_s2h[PW-1:F]);
            r_gs  <= RW'($signed(w_s2g[PW-1:F+1]));
            r_cd3 <= r_cd2;
            r_u3  <= r_u2;
        end
        if (i_en.mul3) begin
            r_val <= RW'($signed(w_s3[PW-1:F+1]));
            r_slp <= r_gs;
        end
    end

    assign o_value = r_val;
    assign o_slope = r_slp;

endmodule

// ----- hdl/catmull_rom_spline_eval.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval - uniform Catmull-Rom position and slope, 3-D
// Path: index, table read, coefficients, Horner steps, output register.
// One transaction per cycle unless stalled; writes land in the table at accept.
// Reset: synchronous, clears the pipeline and sets num_points to 2; table kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module catmull_rom_spline_eval import crs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int NW = $clog2(MAX_POINTS + 1),
    localparam int TW = T_FRAC_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [AW-1:0]                 i_point_index,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic [TW-1:0]                 i_t_param,

    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_value_x,
    output logic signed [COORD_WIDTH-1:0] o_value_y,
    output logic signed [COORD_WIDTH-1:0] o_value_z,
    output logic signed [COORD_WIDTH-1:0] o_slope_x,
    output logic signed [COORD_WIDTH-1:0] o_slope_y,
    output logic signed [COORD_WIDTH-1:0] o_slope_z,

    // Configuration: num_points
    input  logic                          i_cfg_we,
    input  logic [NW-1:0]                 i_cfg_wdata
);

    // Pipeline stages ahead of the output register:
    //   0 index scale, 1 table read, 2 coefficients, 3..5 Horner steps.
    // Each stage loads when it is empty or its successor moves, so bubbles
    // close up and input keeps flowing while a result waits on the output.
    localparam int NSTG = 6;
    localparam int RW   = COORD_WIDTH + GUARD_BITS;

    localparam logic [AW:0] IDX_LIMIT = (AW+1)'(MAX_POINTS);
    localparam logic signed [RW-1:0] SAT_HI = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic [NW-1:0]   r_num_points;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic            w_rdy_out;
    logic            w_in_acc;
    logic            w_wr_en;
    logic            r_out_valid;
    t_lane_en        w_lane_en;

    logic [AW-1:0] w_ia, w_ib, w_ic, w_id;
    logic [TW-1:0] w_u;

    logic signed [RW-1:0] w_val_x, w_val_y, w_val_z;
    logic signed [RW-1:0] w_slp_x, w_slp_y, w_slp_z;

    logic signed [COORD_WIDTH-1:0] r_value_x, r_value_y, r_value_z;
    logic signed [COORD_WIDTH-1:0] r_slope_x, r_slope_y, r_slope_z;

    // Clip a lane result to the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] f_sat(
        input logic signed [RW-1:0] v
    );
        if (v > SAT_HI) begin
            return SAT_HI[COORD_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    // Ready chain, from the output register back to the index stage
    always_comb begin
        w_rdy_out       = !r_out_valid || !i_out_stall;
        w_rdy[NSTG-1]   = !r_vld[NSTG-1] || w_rdy_out;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Accept a transaction only when the index stage can take it: a write
    // then never overtakes an evaluation that has yet to read the table.
    assign w_in_acc   = i_in_valid && w_rdy[0];
    assign o_in_stall = !w_rdy[0];

    // Drop writes beyond the table
    assign w_wr_en = w_in_acc && (i_operation == OP_WRITE)
                     && ({1'b0, i_point_index} < IDX_LIMIT);

    assign w_lane_en.rd   = w_rdy[1];
    assign w_lane_en.coef = w_rdy[2];
    assign w_lane_en.mul1 = w_rdy[3];
    assign w_lane_en.mul2 = w_rdy[4];
    assign w_lane_en.mul3 = w_rdy[5];

    // Hold valid flags and the point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_num_points <= NW'(NUM_POINTS_MIN);
        end else begin
            if (i_cfg_we) begin
                r_num_points <= i_cfg_wdata;
            end
            if (w_rdy[0]) begin
                r_vld[0] <= w_in_acc && (i_operation == OP_EVAL);
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_rdy_out) begin
                r_out_valid <= r_vld[NSTG-1];
            end
        end
    end

    crs_index #(
        .MAX_POINTS  (MAX_POINTS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_index (
        .i_clk (i_clk),
        .i_en  (w_rdy[0]),
        .i_t   (i_t_param),
        .i_num (r_num_points),
        .o_ia  (w_ia),
        .o_ib  (w_ib),
        .o_ic  (w_ic),
        .o_id  (w_id),
        .o_u   (w_u)
    );

    // One lane per axis, all stepping together
    crs_lane #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lane_x (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_point_index),
        .i_wr_data (i_point_x),
        .i_ia      (w_ia),
        .i_ib      (w_ib),
        .i_ic      (w_ic),
        .i_id      (w_id),
        .i_u       (w_u),
        .o_value   (w_val_x),
        .o_slope   (w_slp_x)
    );

    crs_lane #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lane_y (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_point_index),
        .i_wr_data (i_point_y),
        .i_ia      (w_ia),
        .i_ib      (w_ib),
        .i_ic      (w_ic),
        .i_id      (w_id),
        .i_u       (w_u),
        .o_value   (w_val_y),
        .o_slope   (w_slp_y)
    );

    crs_lane #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lane_z (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_point_index),
        .i_wr_data (i_point_z),
        .i_ia      (w_ia),
        .i_ib      (w_ib),
        .i_ic      (w_ic),
        .i_id      (w_id),
        .i_u       (w_u),
        .o_value   (w_val_z),
        .o_slope   (w_slp_z)
    );

    // Merge stage: saturate the three lanes into one result transaction
    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_value_x <= f_sat(w_val_x);
            r_value_y <= f_sat(w_val_y);
            r_value_z <= f_sat(w_val_z);
            r_slope_x <= f_sat(w_slp_x);
            r_slope_y <= f_sat(w_slp_y);
            r_slope_z <= f_sat(w_slp_z);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_x   = r_value_x;
    assign o_value_y   = r_value_y;
    assign o_value_z   = r_value_z;
    assign o_slope_x   = r_slope_x;
    assign o_slope_y   = r_slope_y;
    assign o_slope_z   = r_slope_z;

`ifndef SYNTHESIS
    // A write never enters the evaluation pipeline
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_operation == OP_WRITE)) |=> !r_vld[0])
        else $error("write transaction entered the pipeline");

    // An accepted evaluation occupies the index stage next cycle
    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_operation == OP_EVAL)) |=> r_vld[0])
        else $error("evaluate transaction lost at entry");

    // A full pipeline behind a stalled output must stall the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && (r_vld == '1)) |-> o_in_stall)
        else $error("input accepted while pipeline full and blocked");

    // The last stage keeps an item that cannot move
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !w_rdy_out) |=> r_vld[NSTG-1])
        else $error("last stage dropped a blocked item");
`endif

endmodule

// ----- tb/sv/catmull_rom_spline_eval_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_tb - self-checking bench for the spline evaluator
// A directed table covers coordinate extremes, the ends of the curve parameter,
// a parameter above one and a point count below the minimum. A long random
// run follows, over a range of point counts. Each evaluation is scored against
// a bit-exact fixed-point predictor or a written-out flat-curve result. Both
// handshakes idle at random, the output is held off once long enough to back
// the pipeline up, and the sender pauses once until the output has caught up.
// ----------------------------------------------------------------------------

module catmull_rom_spline_eval_tb;
    import crs_pkg::*;

    localparam int FB         = T_FRAC_BITS_DEF;
    localparam int NPTS       = MAX_POINTS_DEF;
    localparam int T_ONE      = 1 << FB;
    localparam int T_TOP      = (1 << (FB + 1)) - 1;
    localparam int PIPE_PAD   = 12;       // a margin over the pipeline latency
    localparam int HOLD_LEN   = 300;      // cycles of the long output hold-off
    localparam int PHASES     = 14;
    localparam int PHASE_LEN  = 125;      // random transactions per phase
    localparam int CYCLE_CAP  = 200000;
    localparam int SHOW_MAX   = 10;

    // One input transaction, as the ports carry it
    typedef struct packed {
        logic        op;
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [16:0] t;
    } t_spline_req;

    // One result transaction; field order matches the name list below
    typedef struct packed {
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
        logic [31:0] slope_z;
    } t_curve_point;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [6:0]   cfg_val;
        logic         typed;      // want is written out, not predicted
        t_spline_req  req;
        t_curve_point want;
    } t_stim_row;

    string field_name [6] = '{"value_x", "value_y", "value_z",
                              "slope_x", "slope_y", "slope_z"};

    // ------------------------------------------------------------------------
    // Block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_operation   = OP_WRITE;
    logic [5:0]         i_point_index = '0;
    logic signed [31:0] i_point_x     = '0;
    logic signed [31:0] i_point_y     = '0;
    logic signed [31:0] i_point_z     = '0;
    logic [16:0]        i_t_param     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic signed [31:0] o_value_x;
    logic signed [31:0] o_value_y;
    logic signed [31:0] o_value_z;
    logic signed [31:0] o_slope_x;
    logic signed [31:0] o_slope_y;
    logic signed [31:0] o_slope_z;
    logic               i_cfg_we      = 1'b0;
    logic [6:0]         i_cfg_wdata   = 7'(NUM_POINTS_MIN);

    catmull_rom_spline_eval uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_t_param     (i_t_param),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_x     (o_value_x),
        .o_value_y     (o_value_y),
        .o_value_z     (o_value_z),
        .o_slope_x     (o_slope_x),
        .o_slope_y     (o_slope_y),
        .o_slope_z     (o_slope_z),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a shadow of the point table and the point count
    // ------------------------------------------------------------------------
    logic signed [31:0] tab_x [NPTS];
    logic signed [31:0] tab_y [NPTS];
    logic signed [31:0] tab_z [NPTS];
    bit                 written [NPTS];
    logic [6:0]         cfg_points = 7'(NUM_POINTS_MIN);

    t_curve_point spline_due [$];     // evaluations accepted, result not yet seen

    // Run bookkeeping
    bit  calm      = 1'b0;            // suppress random idling on both sides
    bit  hold_req  = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  fail_count  = 0;
    int  shown       = 0;
    int  n_writes    = 0;
    int  n_evals     = 0;
    int  n_results   = 0;
    int  n_cfg       = 0;
    int  cycle_count = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, spline_due.size());
            $display("FAIL catmull_rom_spline_eval");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // Round half up, then drop s fraction bits (arithmetic shift floors)
    function automatic longint round_drop(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Position and slope of one axis by Horner steps, as {position, slope}
    function automatic logic [63:0] cr_axis(longint a, longint b, longint c,
                                            longint d, longint u);
        longint ca, cb, cc, cd, h, g;
        ca = -a + 3 * b - 3 * c + d;
        cb = 2 * a - 5 * b + 4 * c - d;
        cc = c - a;
        cd = 2 * b;
        h = round_drop(ca * u + (cb <<< FB), FB);
        h = round_drop(h * u + (cc <<< FB), FB);
        h = round_drop(h * u + (cd <<< FB), FB + 1);
        g = round_drop(3 * ca * u + ((2 * cb) <<< FB), FB);
        g = round_drop(g * u + (cc <<< FB), FB + 1);
        return {clip32(h), clip32(g)};
    endfunction

    // Point counts outside the legal range are pinned to it
    function automatic int eff_points(logic [6:0] n);
        if (n < NUM_POINTS_MIN)
            return NUM_POINTS_MIN;
        if (n > NPTS)
            return NPTS;
        return int'(n);
    endfunction

    function automatic t_curve_point spline_at(logic [16:0] t);
        t_curve_point r;
        int n, s, tc, tns, sec, u, ia, id;
        n   = eff_points(cfg_points);
        s   = n - 1;
        tc  = (t > T_ONE) ? T_ONE : int'(t);
        tns = tc * s;
        sec = tns >> FB;
        if (sec > s - 1)
            sec = s - 1;
        u  = tns - (sec << FB);
        ia = (sec == 0) ? 0 : sec - 1;
        id = (sec + 2 > n - 1) ? n - 1 : sec + 2;
        {r.value_x, r.slope_x} = cr_axis(tab_x[ia], tab_x[sec], tab_x[sec + 1], tab_x[id], u);
        {r.value_y, r.slope_y} = cr_axis(tab_y[ia], tab_y[sec], tab_y[sec + 1], tab_y[id], u);
        {r.value_z, r.slope_z} = cr_axis(tab_z[ia], tab_z[sec], tab_z[sec + 1], tab_z[id], u);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: score results and drive the output stall
    // ------------------------------------------------------------------------
    t_curve_point seen_pt, want_pt;

    always @(posedge i_clk) begin
        // Score a transaction that completes at this edge
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            seen_pt = {o_value_x, o_value_y, o_value_z, o_slope_x, o_slope_y, o_slope_z};
            n_results++;
            if (spline_due.size() == 0) begin
                fail_count++;
                if (shown < SHOW_MAX) begin
                    $display("unexpected result at cycle %0d: %h", cycle_count, seen_pt);
                    shown++;
                end
            end else begin
                want_pt = spline_due.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (seen_pt[32 * (5 - k) +: 32] !== want_pt[32 * (5 - k) +: 32]) begin
                        fail_count++;
                        if (shown < SHOW_MAX) begin
                            $display("result %0d %s: expected %h, got %h", n_results,
                                     field_name[k], want_pt[32 * (5 - k) +: 32],
                                     seen_pt[32 * (5 - k) +: 32]);
                            shown++;
                        end
                    end
                end
            end
        end

        // Pick the stall for the next cycle: the long hold-off first, then noise
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then update the shadow
    task automatic send_item(input t_spline_req req, input bit typed,
                             input t_curve_point want);
        while (!calm && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= req.op;
        i_point_index <= req.idx;
        i_point_x     <= req.x;
        i_point_y     <= req.y;
        i_point_z     <= req.z;
        i_t_param     <= req.t;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (req.op == OP_WRITE) begin
            tab_x[req.idx]   = req.x;
            tab_y[req.idx]   = req.y;
            tab_z[req.idx]   = req.z;
            written[req.idx] = 1'b1;
            n_writes++;
        end else begin
            spline_due = {spline_due, (typed ? want : spline_at(req.t))};
            n_evals++;
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic await_results();
        i_in_valid <= 1'b0;
        while (spline_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Change the point count only with the pipeline empty
    task automatic set_points(input logic [6:0] n);
        await_results();
        repeat (PIPE_PAD) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_points   = n;
        n_cfg++;
    endtask

    // Coordinates: extremes, zero, full-range noise and values near zero
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
        endcase
    endfunction

    // Curve parameter: ends, above one, near section boundaries, anywhere
    function automatic logic [16:0] rand_t(int s);
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = T_ONE;
            2:       v = $urandom_range(T_TOP, T_ONE + 1);
            3, 4:    v = ($urandom_range(s) * T_ONE) / s + $urandom_range(2) - 1;
            default: v = $urandom_range(T_ONE);
        endcase
        if (v < 0)
            v = 0;
        return 17'(v);
    endfunction

    // Mostly evaluations; writes land anywhere in the table. Unused fields of
    // each transaction carry noise.
    function automatic t_spline_req random_req(int n_eff);
        t_spline_req r;
        r.op  = ($urandom_range(99) < 25) ? OP_WRITE : OP_EVAL;
        r.idx = 6'($urandom_range(NPTS - 1));
        r.x   = rand_coord();
        r.y   = rand_coord();
        r.z   = rand_coord();
        r.t   = (r.op == OP_EVAL) ? rand_t(n_eff - 1) : 17'($urandom_range(T_TOP));
        return r;
    endfunction

    function automatic t_stim_row row_write(int idx, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.req  = '{op: OP_WRITE, idx: 6'(idx), x: x, y: y, z: z, t: '0};
        return r;
    endfunction

    function automatic t_stim_row row_eval(int t);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.req  = '{op: OP_EVAL, idx: '0, x: '0, y: '0, z: '0, t: 17'(t)};
        return r;
    endfunction

    // Evaluation on a flat curve: position is the point itself, slope zero
    function automatic t_stim_row row_flat(int t, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z);
        t_stim_row r;
        r       = row_eval(t);
        r.typed = 1'b1;
        r.want  = '{value_x: x, value_y: y, value_z: z,
                    slope_x: '0, slope_y: '0, slope_z: '0};
        return r;
    endfunction

    function automatic t_stim_row row_cfg(int n);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_val = 7'(n);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    t_stim_row dir_rows [$];
    int        phase_cfg [PHASES] = '{64, 2, 127, 3, 0, 4, 65, 1, 5, -1, -1, -1, -1, 64};

    // Append one row to the directed table
    function automatic void add_row(t_stim_row r);
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        int          ne;
        logic [6:0]  nv;
        t_spline_req fill;

        // Directed rows; the reset count of two points reads entries 0 and 1 only
        add_row(row_write(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        add_row(row_write(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        add_row(row_flat(0,     32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        add_row(row_flat(T_ONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        add_row(row_flat(T_TOP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        add_row(row_flat(T_ONE / 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        add_row(row_write(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000));
        add_row(row_write(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        add_row(row_eval(0));
        add_row(row_eval(1));
        add_row(row_eval(T_ONE - 1));
        add_row(row_eval(T_ONE));
        add_row(row_eval(T_TOP));
        // Alternating extremes overshoot and saturate in the middle section
        add_row(row_write(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        add_row(row_write(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        add_row(row_write(NPTS - 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_row(row_cfg(4));
        add_row(row_eval(T_ONE / 2));
        add_row(row_eval(10923));
        add_row(row_eval(T_ONE));
        // A count below the minimum behaves as two points
        add_row(row_cfg(0));
        add_row(row_eval(49152));
        add_row(row_eval(T_TOP));
        add_row(row_cfg(NUM_POINTS_MIN));

        // Hold reset, then release it for good
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                set_points(dir_rows[k].cfg_val);
            else
                send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases, one point count each; negative entries pick a count
        for (int p = 0; p < PHASES; p++) begin
            nv = (phase_cfg[p] < 0) ? 7'($urandom_range(NPTS, NUM_POINTS_MIN))
                                    : 7'(phase_cfg[p]);
            set_points(nv);
            ne = eff_points(nv);

            // Fill any entry this count can read before evaluating
            for (int i = 0; i < ne; i++) begin
                if (!written[i]) begin
                    fill     = random_req(ne);
                    fill.op  = OP_WRITE;
                    fill.idx = 6'(i);
                    send_item(fill, 1'b0, '0);
                end
            end

            calm = (p == 6 || p == 7);
            for (int i = 0; i < PHASE_LEN; i++) begin
                // Back the pipeline up against a long output hold-off
                if (p == 2 && i == 30)
                    hold_req = 1'b1;
                // Pause input until the output has caught up
                if (p == 4 && i == 60)
                    await_results();
                send_item(random_req(ne), 1'b0, '0);
            end
            calm = 1'b0;
        end

        await_results();
        repeat (2 * PIPE_PAD) @(posedge i_clk);
        if (spline_due.size() != 0)
            fail_count++;

        $display("Covered %0d point writes and %0d evaluations over %0d point-count settings,",
                 n_writes, n_evals, n_cfg);
        $display("with %0d results scored and %0d field mismatches or stray results.",
                 n_results, fail_count);
        if (fail_count == 0)
            $display("PASS catmull_rom_spline_eval");
        else
            $display("FAIL catmull_rom_spline_eval");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/crs_pkg.sv
hdl/crs_index.sv
hdl/crs_lane.sv
hdl/catmull_rom_spline_eval.sv
tb/sv/catmull_rom_spline_eval_tb.sv
